>>> rtl/ewc_pkg.sv
// ----------------------------------------------------------------------------
// ewc_pkg
// Types and constants shared by the energy-weighted centroid accumulator.
// ----------------------------------------------------------------------------
package ewc_pkg;

    localparam int COORD_W  = 16;   // eta / phi width
    localparam int CELL_E_W = 24;   // cell energy width
    localparam int TOTAL_W  = 32;   // accumulated energy width
    localparam int NUM_W    = 48;   // numerator magnitude width
    localparam int DEN_W    = 32;   // divisor width (|total| + |cell| < 2^32)
    localparam int QUO_W    = 16;   // quotient magnitude width
    localparam int PROD_W   = COORD_W + TOTAL_W + 1;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                        op;
        logic signed [COORD_W-1:0]   cell_eta;
        logic signed [COORD_W-1:0]   cell_phi;
        logic signed [CELL_E_W-1:0]  cell_energy;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]   centroid_eta_out;
        logic signed [COORD_W-1:0]   centroid_phi_out;
        logic signed [TOTAL_W-1:0]   total_energy_out;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_OLD,
        S_MUL_CELL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

endpackage

>>> rtl/ewc_div.sv
// ----------------------------------------------------------------------------
// ewc_div
// Radix-2 restoring divider, one quotient bit per cycle. The quotient is
// known to fit QUO_W bits, so the upper numerator bits preload the remainder.
// ----------------------------------------------------------------------------
module ewc_div
    import ewc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic [QUO_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_low;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_fit;

    always_comb begin
        w_trial = {r_rem, r_low[QUO_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_fit   = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:QUO_W];
            r_low <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits DEN_W bits
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_low <= {r_low[QUO_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_low;

endmodule

>>> rtl/energy_weighted_centroid_accumulator_top.sv
// ----------------------------------------------------------------------------
// energy_weighted_centroid_accumulator_top
// Folds calorimeter cells into one energy-weighted cluster centroid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries one t_in_item per
//   transaction: op selects accumulate or clear. Output channel o_out_valid /
//   i_out_stall returns one t_out_item per input transaction with the
//   updated centroid and saturated total energy.
//   An accumulate with nonzero weight runs two products on a shared
//   multiplier and a 16-step serial divide for each of eta and phi, in the
//   steps MUL_OLD, MUL_CELL, DIV_GO and DIV_WAIT, first for eta and then
//   for phi, and ends in DONE; the next item is taken only once the block
//   is back in IDLE. A clear, or an accumulate where both weights are zero,
//   goes from acceptance straight to DONE.
//   o_in_stall is high while an item is in work. The result sits in an
//   output register; while the receiver stalls it holds, and a finished item
//   waits in its last step until that register frees up.
//   Reset zeroes the centroid and energy and empties the output register.
// ----------------------------------------------------------------------------
module energy_weighted_centroid_accumulator_top
    import ewc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_state r_state, n_state;

    logic signed [COORD_W-1:0]  r_eta, r_phi;
    logic signed [TOTAL_W-1:0]  r_total;
    logic signed [COORD_W-1:0]  r_cell_eta, r_cell_phi;
    logic [TOTAL_W-1:0]         r_wo;
    logic [CELL_E_W-1:0]        r_wn;
    logic [DEN_W-1:0]           r_den;
    logic                       r_sel;      // 0 eta, 1 phi
    logic signed [PROD_W-1:0]   r_num;
    logic                       r_out_valid;
    t_out_item                  r_out_data;

    logic                       w_accept;
    logic                       w_zero;
    logic [TOTAL_W:0]           w_wo_ext;
    logic [CELL_E_W:0]          w_wn_ext;
    logic signed [TOTAL_W:0]    w_esum;
    logic signed [TOTAL_W-1:0]  w_esat;
    logic signed [COORD_W-1:0]  w_mul_a;
    logic signed [TOTAL_W:0]    w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic                       w_neg;
    logic [PROD_W-1:0]          w_mag;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [QUO_W-1:0]           w_quo;
    logic signed [COORD_W-1:0]  w_coord;
    logic                       w_out_free;

    function automatic logic signed [COORD_W-1:0] floor_half(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_wo_ext = r_total[TOTAL_W-1] ? ((TOTAL_W+1)'(0) - {r_total[TOTAL_W-1], r_total})
                                      : {1'b0, r_total};
        w_wn_ext = i_in_data.cell_energy[CELL_E_W-1]
                 ? ((CELL_E_W+1)'(0) - {i_in_data.cell_energy[CELL_E_W-1],
                                        i_in_data.cell_energy})
                 : {1'b0, i_in_data.cell_energy};
        w_zero   = (r_total == '0) && (i_in_data.cell_energy == '0);
        w_esum   = {r_total[TOTAL_W-1], r_total}
                 + (TOTAL_W+1)'(signed'(i_in_data.cell_energy));
        if (w_esum[TOTAL_W] != w_esum[TOTAL_W-1]) begin
            w_esat = w_esum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                     : {1'b0, {(TOTAL_W-1){1'b1}}};
        end else begin
            w_esat = w_esum[TOTAL_W-1:0];
        end
    end

    // shared multiplier: old coordinate times |total|, then cell times |cell energy|
    always_comb begin
        if (r_state == S_MUL_OLD) begin
            w_mul_a = r_sel ? r_phi : r_eta;
            w_mul_b = {1'b0, r_wo};
        end else begin
            w_mul_a = r_sel ? r_cell_phi : r_cell_eta;
            w_mul_b = {{(TOTAL_W+1-CELL_E_W){1'b0}}, r_wn};
        end
        w_prod = w_mul_a * w_mul_b;
    end

    assign w_neg       = r_num[PROD_W-1];
    assign w_mag       = w_neg ? (PROD_W'(0) - r_num) : r_num;
    assign w_div_start = (r_state == S_DIV_GO);
    assign w_coord     = w_neg ? (COORD_W'(0) - w_quo) : w_quo;

    ewc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mag[NUM_W-1:0]),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.op == OP_CLEAR || w_zero) ? S_DONE : S_MUL_OLD;
                end
            end
            S_MUL_OLD:  n_state = S_MUL_CELL;
            S_MUL_CELL: n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = r_sel ? S_DONE : S_MUL_OLD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_eta       <= '0;
            r_phi       <= '0;
            r_total     <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_sel <= 1'b0;
                if (i_in_data.op == OP_CLEAR) begin
                    r_eta   <= '0;
                    r_phi   <= '0;
                    r_total <= '0;
                end else begin
                    // weights are captured now, so the total can move on
                    r_total <= w_esat;
                    if (w_zero) begin
                        r_eta <= floor_half(r_eta, i_in_data.cell_eta);
                        r_phi <= floor_half(r_phi, i_in_data.cell_phi);
                    end
                end
            end else if (r_state == S_DIV_WAIT && w_div_done) begin
                if (r_sel) begin
                    r_phi <= w_coord;
                end else begin
                    r_eta <= w_coord;
                end
                r_sel <= 1'b1;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cell_eta <= i_in_data.cell_eta;
            r_cell_phi <= i_in_data.cell_phi;
            r_wo       <= w_wo_ext[TOTAL_W-1:0];
            r_wn       <= w_wn_ext[CELL_E_W-1:0];
            r_den      <= w_wo_ext[DEN_W-1:0] + DEN_W'(w_wn_ext);
        end
        if (r_state == S_MUL_OLD) begin
            r_num <= w_prod;
        end else if (r_state == S_MUL_CELL) begin
            r_num <= r_num + w_prod;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data.centroid_eta_out <= r_eta;
            r_out_data.centroid_phi_out <= r_phi;
            r_out_data.total_energy_out <= r_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> dv/ewc_centroid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ewc_centroid_checker
// Watches both channels of the centroid accumulator, folds every accepted
// cell into its own copy of the cluster, and compares each returned
// transaction field by field with the oldest predicted centroid.
// ----------------------------------------------------------------------------
module ewc_centroid_checker
    import ewc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    localparam longint ENERGY_MAX = 64'sd2147483647;
    localparam longint ENERGY_MIN = -64'sd2147483648;

    t_out_item cluster;           // predicted centroid and energy
    t_out_item centroid_due_q[$]; // predicted results not yet returned
    t_out_item want;
    int        fail_count;
    int        checked;

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Fold one transaction into the cluster and return the updated cluster.
    function automatic t_out_item fold_cell(input t_out_item cur, input t_in_item it);
        t_out_item nxt;
        longint    old_eta, old_phi, old_e, c_eta, c_phi, c_e;
        longint    w_old, w_new, den, sum;
        nxt = '0;
        if (it.op == OP_CLEAR) return nxt;
        old_eta = $signed(cur.centroid_eta_out);
        old_phi = $signed(cur.centroid_phi_out);
        old_e   = $signed(cur.total_energy_out);
        c_eta   = $signed(it.cell_eta);
        c_phi   = $signed(it.cell_phi);
        c_e     = $signed(it.cell_energy);
        w_old   = magnitude(old_e);
        w_new   = magnitude(c_e);
        den     = w_old + w_new;
        if (den == 0) begin
            // no weight on either side: floor of the plain mean
            nxt.centroid_eta_out = 16'((old_eta + c_eta) >>> 1);
            nxt.centroid_phi_out = 16'((old_phi + c_phi) >>> 1);
        end else begin
            nxt.centroid_eta_out = 16'((old_eta * w_old + c_eta * w_new) / den);
            nxt.centroid_phi_out = 16'((old_phi * w_old + c_phi * w_new) / den);
        end
        sum = old_e + c_e;
        if (sum > ENERGY_MAX) sum = ENERGY_MAX;
        if (sum < ENERGY_MIN) sum = ENERGY_MIN;
        nxt.total_energy_out = 32'(sum);
        return nxt;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cluster = '0;
            centroid_due_q.delete();
            fail_count = 0;
            checked = 0;
        end else begin
            // Retire the result before predicting: a result never belongs to a
            // transaction accepted at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (centroid_due_q.size() == 0) begin
                    $error("unexpected result transaction: eta %0d phi %0d energy %0d",
                           i_out_data.centroid_eta_out, i_out_data.centroid_phi_out,
                           i_out_data.total_energy_out);
                    fail_count++;
                end else begin
                    want = centroid_due_q.pop_front();
                    checked++;
                    if (i_out_data.centroid_eta_out !== want.centroid_eta_out) begin
                        $error("centroid_eta_out: expected %0d, got %0d",
                               want.centroid_eta_out, i_out_data.centroid_eta_out);
                        fail_count++;
                    end
                    if (i_out_data.centroid_phi_out !== want.centroid_phi_out) begin
                        $error("centroid_phi_out: expected %0d, got %0d",
                               want.centroid_phi_out, i_out_data.centroid_phi_out);
                        fail_count++;
                    end
                    if (i_out_data.total_energy_out !== want.total_energy_out) begin
                        $error("total_energy_out: expected %0d, got %0d",
                               want.total_energy_out, i_out_data.total_energy_out);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                cluster = fold_cell(cluster, i_in_data);
                centroid_due_q.push_back(cluster);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= centroid_due_q.size();
        o_checked    <= checked;
    end

endmodule

>>> dv/energy_weighted_centroid_accumulator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// energy_weighted_centroid_accumulator_top_tb
// Drives directed and random cell sequences into the centroid accumulator
// under four idle/stall mixes; the checker predicts and compares every
// result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module energy_weighted_centroid_accumulator_top_tb;
    import ewc_pkg::*;

    localparam int QUIET_LIMIT  = 2000; // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 430;
    localparam int SAT_RUN_LEN  = 300;

    typedef enum int {RUN_TINY, RUN_WIDE, RUN_CANCEL, RUN_SAT_POS, RUN_SAT_NEG} run_kind_e;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int quiet_cycles  = 0;
    int sent          = 0;
    int clears_sent   = 0;
    int fail_count;
    int pending;
    int checked;

    energy_weighted_centroid_accumulator_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    ewc_centroid_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 clk = ~clk;

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(negedge clk) begin
        out_stall <= rst_n && roll(dst_stall_pct);
    end

    // End the run when neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cell(input logic op, input logic signed [15:0] eta,
                             input logic signed [15:0] phi, input logic signed [23:0] en);
        bit go;
        go = 1'b0;
        while (!go) begin
            @(negedge clk);
            if (roll(src_idle_pct)) begin
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_data  <= '{op: op, cell_eta: eta, cell_phi: phi, cell_energy: en};
                go = 1'b1;
            end
        end
        // hold the transaction until the block takes it
        do @(posedge clk); while (in_stall);
        sent++;
        if (op == OP_CLEAR) clears_sent++;
    endtask

    // A clear, then cells on the energy pattern; non-SAT runs mix in clears.
    task automatic run_cells(input run_kind_e kind, input int len);
        logic signed [23:0] en;
        logic signed [23:0] prev_en;
        prev_en = '0;
        send_cell(OP_CLEAR, 16'($urandom), 16'($urandom), 24'($urandom));
        for (int i = 0; i < len; i++) begin
            case (kind)
                RUN_TINY:   en = 24'($urandom_range(16)) - 24'sd8;
                RUN_WIDE:   en = 24'($urandom);
                RUN_CANCEL: begin
                    // cancel the previous cell's energy every other cell
                    if (i % 2) en = -prev_en;
                    else if (roll(25)) en = '0;
                    else en = 24'($urandom_range(8191)) - 24'sd4096;
                end
                RUN_SAT_POS: en = roll(10) ? 24'($urandom)
                                           : 24'sd8388607 - 24'($urandom_range(4095));
                default:     en = roll(10) ? 24'($urandom)
                                           : -24'sd8388608 + 24'($urandom_range(4095));
            endcase
            prev_en = en;
            if (kind != RUN_SAT_POS && kind != RUN_SAT_NEG && roll(3))
                send_cell(OP_CLEAR, 16'($urandom), 16'($urandom), 24'($urandom));
            else
                send_cell(OP_ACCUM, pick_coord(), pick_coord(), en);
        end
    endtask

    initial begin
        int        phase_start;
        run_kind_e kind;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // both weights zero: floor of the mean, odd and extreme sums
        send_cell(OP_ACCUM, -16'sd3, 16'sd5, 24'sd0);
        send_cell(OP_ACCUM, 16'sh7fff, 16'sh8000, 24'sd0);
        send_cell(OP_ACCUM, 16'sh8000, 16'sh7fff, 24'sd0);
        // energy extremes, total back through zero
        send_cell(OP_ACCUM, 16'sd100, -16'sd100, 24'sh7fffff);
        send_cell(OP_ACCUM, 16'sh8000, 16'sh7fff, 24'sh800000);
        send_cell(OP_ACCUM, 16'sh7fff, 16'sh8000, 24'sd1);
        send_cell(OP_ACCUM, 16'sd7, -16'sd7, 24'sd0);
        // zero cell weight against a stored weight leaves the centroid
        send_cell(OP_ACCUM, 16'sd300, 16'sd300, 24'sd1000);
        send_cell(OP_ACCUM, 16'sh8000, 16'sh7fff, 24'sd0);
        // clear ignores its cell fields
        send_cell(OP_CLEAR, -16'sd1, -16'sd1, -24'sd1);
        send_cell(OP_ACCUM, -16'sd1, -16'sd1, -24'sd1);
        send_cell(OP_ACCUM, 16'sd1, 16'sd1, 24'sd2);
        send_cell(OP_CLEAR, 16'sd0, 16'sd0, 24'sd0);
        // negative quotient truncates toward zero
        send_cell(OP_ACCUM, 16'sd0, 16'sd0, 24'sd1);
        send_cell(OP_ACCUM, -16'sd3, -16'sd3, -24'sd1);
        send_cell(OP_CLEAR, 16'sd0, 16'sd0, 24'sd0);
        send_cell(OP_CLEAR, 16'sh7fff, 16'sh8000, 24'sh7fffff);
        send_cell(OP_ACCUM, 16'sh7fff, 16'sh7fff, 24'sh7fffff);
        send_cell(OP_ACCUM, 16'sh8000, 16'sh8000, -24'sd8388607);
        send_cell(OP_ACCUM, 16'sh8000, 16'sh8000, 24'sd0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 63; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 63; end
                default: begin src_idle_pct = 9; dst_stall_pct = 9; end
            endcase
            phase_start = sent;
            // drive the total into both saturation limits once
            if (ph == 1) run_cells(RUN_SAT_POS, SAT_RUN_LEN);
            if (ph == 3) run_cells(RUN_SAT_NEG, SAT_RUN_LEN);
            while (sent - phase_start < PHASE_ITEMS) begin
                case ($urandom_range(2))
                    0:       kind = RUN_TINY;
                    1:       kind = RUN_WIDE;
                    default: kind = RUN_CANCEL;
                endcase
                run_cells(kind, $urandom_range(1, 40));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d cell transactions sent (%0d clears), %0d results compared,",
                 sent, clears_sent, checked);
        $display("tb: over no-idle, sender-idle, receiver-stall and mixed phases");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/ewc_pkg.sv
rtl/ewc_div.sv
rtl/energy_weighted_centroid_accumulator_top.sv
dv/ewc_centroid_checker.sv
dv/energy_weighted_centroid_accumulator_top_tb.sv
